/* hdl/sdst_pkg.sv */
// package for the set difference and subset test block
// holds shared widths, request codes, state encoding and control structs
// no dependencies
package sdst_pkg;

  // element width and default table size
  localparam int ELEM_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;       // request taken this cycle
    logic start_query;  // latch query element, restart scan
    logic issue_read;   // read next table entry
    logic finish;       // write result to output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_query;     // pending request is a query
    logic scan_done;    // every loaded entry has been read
    logic out_free;     // output register can take a result
  } stat_t;

endpackage

/* hdl/sdst_if.sv */
// request and result channel interfaces for the set difference block
// valid/ready handshake with payload; depends on sdst_pkg

// request channel
interface sdst_in_if
  import sdst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [ELEM_W-1:0] element;
  logic                     last_of_set;

  modport source (output valid, req_type, element, last_of_set, input ready);
  modport sink   (input valid, req_type, element, last_of_set, output ready);
endinterface

// result channel
interface sdst_out_if
  import sdst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] query_value;
  logic                     found_in_table;
  logic                     in_difference;
  logic                     subset_so_far;
  logic                     last_out;
  logic                     overflowed;

  modport source (output valid, query_value, found_in_table, in_difference,
                  subset_so_far, last_out, overflowed, input ready);
  modport sink   (input valid, query_value, found_in_table, in_difference,
                  subset_so_far, last_out, overflowed, output ready);
endinterface

/* hdl/sdst_ctrl.sv */
// controller state machine for the set difference block
// sequences request intake, table scan and result hand-off; uses sdst_pkg
module sdst_ctrl
  import sdst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.start_query = 1'b0;
    cmd.issue_read  = 1'b0;
    cmd.finish      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.accept      = in_valid;
        cmd.start_query = in_valid && stat.is_query;
      end
      ST_SCAN: begin
        cmd.issue_read = !stat.scan_done;
      end
      ST_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/sdst_dp.sv */
// datapath for the set difference block: reference table memory,
// entry count, scan index, compare, subset and overflow flags, result register
// uses sdst_pkg
module sdst_dp
  import sdst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request payload
  input  logic [1:0]               in_req_type,
  input  logic signed [ELEM_W-1:0] in_element,
  input  logic                     in_last_of_set,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] out_query_value,
  output logic                     out_found_in_table,
  output logic                     out_in_difference,
  output logic                     out_subset_so_far,
  output logic                     out_last_out,
  output logic                     out_overflowed,
  // control
  input  cmd_t                     cmd,
  output stat_t                    stat
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [ELEM_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [ELEM_W-1:0] rd_data_r;
  logic                     rd_valid_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         idx_r;
  logic                     overflow_r;
  logic                     all_found_r;
  logic                     found_r;
  logic signed [ELEM_W-1:0] qval_r;
  logic                     qlast_r;
  logic                     out_valid_r;
  logic                     subset;
  logic                     do_load;
  logic                     do_clear;
  logic                     has_room;

  // request decode
  assign do_load  = cmd.accept && (in_req_type == REQ_LOAD);
  assign do_clear = cmd.accept && (in_req_type == REQ_CLEAR);
  assign has_room = count_r < CNT_W'(TABLE_DEPTH);

  // status to controller
  assign stat.is_query  = (in_req_type == REQ_QUERY);
  assign stat.scan_done = (idx_r == count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  // table write on load
  always_ff @(posedge clk) begin
    if (do_load && has_room) begin
      table_mem[count_r[IDX_W-1:0]] <= in_element;
    end
  end

  // registered table read during scan
  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      rd_data_r <= table_mem[idx_r[IDX_W-1:0]];
    end
  end

  // entry count and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (do_clear) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (do_load) begin
      if (has_room) begin
        count_r <= count_r + 1'b1;
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  // scan index, read-data valid and match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      rd_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue_read;
      if (cmd.start_query) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.issue_read) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_valid_r && (rd_data_r == qval_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // query element held for the scan
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      qval_r  <= in_element;
      qlast_r <= in_last_of_set;
    end
  end

  // subset tracking, restarts after the last element of a set
  assign subset = all_found_r && found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_found_r <= 1'b1;
    end else if (cmd.finish) begin
      all_found_r <= qlast_r ? 1'b1 : subset;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_query_value    <= qval_r;
      out_found_in_table <= found_r;
      out_in_difference  <= !found_r;
      out_subset_so_far  <= subset;
      out_last_out       <= qlast_r;
      out_overflowed     <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/set_difference_and_subset_test.sv */
// Set difference and subset test, top level.
// Request channel in_ch: req_type clear (empties the table and the overflow
// flag), load (appends element to the reference table) or query (looks the
// element up). Code 3 is taken and ignored. Only a query gives a result on
// out_ch: the element, found / in-difference flags, the running subset flag
// (final on the result with last_out set, restarts after it) and the sticky
// overflow flag, set when a load meets a full table.
// Clear and load need no scan. A query scans the table one entry per cycle
// through the single memory read port before its result is registered.
// Results sit in an output register; a stalled receiver holds the result
// there, further loads and clears are still taken, and a following query
// waits at the end of its scan until the register is free.
// Synchronous reset empties the table (entry count zero), clears overflow
// and sets the subset flag; no clearing pass is needed.
// Depends on sdst_pkg, sdst_if, sdst_ctrl and sdst_dp.
module set_difference_and_subset_test
  import sdst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  sdst_in_if.sink   in_ch,
  sdst_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // controller
  sdst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sdst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_ch.req_type),
    .in_element         (in_ch.element),
    .in_last_of_set     (in_ch.last_of_set),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_query_value    (out_ch.query_value),
    .out_found_in_table (out_ch.found_in_table),
    .out_in_difference  (out_ch.in_difference),
    .out_subset_so_far  (out_ch.subset_so_far),
    .out_last_out       (out_ch.last_out),
    .out_overflowed     (out_ch.overflowed),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

/* tb/sdst_membership_checker.sv */
// checker for the set difference and subset test block: watches both channels,
// predicts each query result from its own copy of the reference table and compares
// depends on sdst_pkg and the channel interfaces in sdst_if
module sdst_membership_checker
  import sdst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  sdst_in_if   in_mon,
  sdst_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   subset_sets,
  output int   dropped_loads
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted query result
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     found;
    logic                     diff;
    logic                     subset;
    logic                     last;
    logic                     ovf;
  } membership_t;

  // predicted block state
  logic signed [ELEM_W-1:0] ref_set [TABLE_DEPTH];
  int unsigned              stored;
  logic                     all_hit;
  logic                     ovf_seen;
  membership_t              results_due[$];

  membership_t              want;
  logic                     hit;

  // linear search over the loaded entries only
  function automatic logic holds(input logic signed [ELEM_W-1:0] v);
    for (int i = 0; i < stored; i++) begin
      if (ref_set[i] === v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [ELEM_W-1:0] exp_v,
                                      input logic [ELEM_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stored        = 0;
      all_hit       = 1'b1;
      ovf_seen      = 1'b0;
      results_due.delete();
      mismatches    = 0;
      outstanding   = 0;
      checked       = 0;
      subset_sets   = 0;
      dropped_loads = 0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          $error("result for element 0x%0h with no query waiting", out_mon.query_value);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          outstanding--;
          checked++;
          check_field("query_value", want.value, out_mon.query_value);
          check_field("found_in_table", ELEM_W'(want.found),
                      ELEM_W'(out_mon.found_in_table));
          check_field("in_difference", ELEM_W'(want.diff),
                      ELEM_W'(out_mon.in_difference));
          check_field("subset_so_far", ELEM_W'(want.subset),
                      ELEM_W'(out_mon.subset_so_far));
          check_field("last_out", ELEM_W'(want.last), ELEM_W'(out_mon.last_out));
          check_field("overflowed", ELEM_W'(want.ovf), ELEM_W'(out_mon.overflowed));
        end
      end

      // update the predicted state on an accepted request
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.req_type)
          REQ_CLEAR: begin
            // subset tracking survives a clear
            stored   = 0;
            ovf_seen = 1'b0;
          end
          REQ_LOAD: begin
            if (stored < TABLE_DEPTH) begin
              ref_set[stored] = in_mon.element;
              stored++;
            end else begin
              ovf_seen = 1'b1;
              dropped_loads++;
            end
          end
          REQ_QUERY: begin
            hit         = holds(in_mon.element);
            want.value  = in_mon.element;
            want.found  = hit;
            want.diff   = !hit;
            want.subset = all_hit & hit;
            want.last   = in_mon.last_of_set;
            want.ovf    = ovf_seen;
            all_hit     = in_mon.last_of_set ? 1'b1 : want.subset;
            if (want.last && want.subset) subset_sets++;
            results_due.push_back(want);
            outstanding++;
          end
          default: begin
            // unused code, no effect
          end
        endcase
      end
    end
  end

endmodule

/* tb/set_difference_and_subset_test_test.sv */
// top of the set difference and subset test bench: clock, reset, request stimulus,
// result back-pressure and the verdict; checking lives in sdst_membership_checker
// depends on sdst_pkg, sdst_if, the block and the checker
module set_difference_and_subset_test_test
  import sdst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH      = DEPTH_DEFAULT;
  localparam int         RAND_ITEMS = 850;
  localparam int         LIMIT      = 600000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  sdst_in_if  in_ch ();
  sdst_out_if out_ch ();

  int mismatches, outstanding, checked, subset_sets, dropped_loads;

  set_difference_and_subset_test #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sdst_membership_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .subset_sets   (subset_sets),
    .dropped_loads (dropped_loads)
  );

  // stimulus bookkeeping
  logic signed [ELEM_W-1:0] loaded_vals[$];
  int  n_sent, n_loads, n_queries, n_clears, n_unused;
  bit  in_calm, out_calm;
  int  cycle_count;
  bit  out_took;
  int  out_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random hold-off after each accepted result
  always @(posedge clk) out_took = out_ch.valid && out_ch.ready;

  always @(negedge clk) begin
    if (out_took) out_hold = out_calm ? 0 : $urandom_range(0, 9);
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // mix of small values for collisions, the extremes and full-range values
  function automatic logic signed [ELEM_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel < 2) return $urandom_range(0, 15) - 8;
    if (sel == 2) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 32'sh7fffffff;
        default: return 32'sh80000000;
      endcase
    end
    return $urandom();
  endfunction

  // present one request; entered and left at a falling edge
  task automatic push_request(input logic [1:0] kind, input logic signed [ELEM_W-1:0] value,
                              input logic last);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.element     <= value;
    in_ch.last_of_set <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    // tally and keep a list of values worth querying
    case (kind)
      REQ_CLEAR: begin
        n_clears++;
        loaded_vals.delete();
      end
      REQ_LOAD: begin
        n_loads++;
        if (loaded_vals.size() < DEPTH) loaded_vals.push_back(value);
      end
      REQ_QUERY: n_queries++;
      default:   n_unused++;
    endcase
    if (kind != REQ_UNUSED) n_sent++;
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int phase, start_sent, n_load, n_q, mode, noise;
    logic signed [ELEM_W-1:0] q_val;
    logic q_last;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_CLEAR;
    in_ch.element     = '0;
    in_ch.last_of_set = 1'b0;
    out_ch.ready      = 1'b0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;
    out_took          = 1'b0;
    out_hold          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: nothing found, zero is an ordinary value
    push_request(REQ_QUERY, '0, 1'b0);
    push_request(REQ_QUERY, 32'sh7fffffff, 1'b1);
    // unused code is swallowed
    push_request(REQ_UNUSED, 32'sh5a5a5a5a, 1'b1);
    // loads with extremes, a duplicate and a stray last flag
    push_request(REQ_LOAD, '0, 1'b1);
    push_request(REQ_LOAD, 32'sh80000000, 1'b0);
    push_request(REQ_LOAD, 32'sh7fffffff, 1'b0);
    push_request(REQ_LOAD, '1, 1'b0);
    push_request(REQ_LOAD, '1, 1'b0);
    // a set fully inside the table
    push_request(REQ_QUERY, '1, 1'b0);
    push_request(REQ_QUERY, 32'sh80000000, 1'b0);
    push_request(REQ_QUERY, '0, 1'b1);
    // a set with one miss
    push_request(REQ_QUERY, 32'sd1, 1'b0);
    push_request(REQ_QUERY, 32'sh7fffffff, 1'b1);
    // clear keeps the running subset flag
    push_request(REQ_CLEAR, 32'sh12345678, 1'b1);
    push_request(REQ_QUERY, 32'sh7fffffff, 1'b0);
    push_request(REQ_LOAD, 32'sd7, 1'b0);
    push_request(REQ_QUERY, 32'sd7, 1'b1);
    push_request(REQ_QUERY, 32'sd7, 1'b1);

    // random sets against random tables
    start_sent = n_sent;
    phase      = 0;
    while (n_sent - start_sent < RAND_ITEMS) begin
      phase++;
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      if (phase == 1 || $urandom_range(0, 5) == 0) wait_drained();

      // table set-up, now and then filled past its depth
      if ($urandom_range(0, 2) != 0)
        push_request(REQ_CLEAR, pick_value(), 1'($urandom_range(0, 1)));
      if (phase == 1 || $urandom_range(0, 19) == 0) n_load = DEPTH + $urandom_range(1, 4);
      else n_load = $urandom_range(0, 12);
      for (int i = 0; i < n_load; i++)
        push_request(REQ_LOAD, pick_value(), 1'($urandom_range(0, 1)));

      // query set, mostly well-formed with occasional noise
      n_q  = $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      for (int k = 0; k < n_q; k++) begin
        noise = $urandom_range(0, 15);
        if (noise == 0) push_request(REQ_UNUSED, $urandom(), 1'($urandom_range(0, 1)));
        else if (noise == 1) push_request(REQ_LOAD, pick_value(), 1'($urandom_range(0, 1)));
        else if (noise == 2) push_request(REQ_CLEAR, pick_value(), 1'($urandom_range(0, 1)));
        if (loaded_vals.size() > 0 && (mode == 0 || $urandom_range(0, 1) == 0))
          q_val = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
        else
          q_val = pick_value();
        // sometimes the set runs on into the next phase
        q_last = (k == n_q - 1) && ($urandom_range(0, 9) != 0);
        push_request(REQ_QUERY, q_val, q_last);
      end
    end

    // drain and let any late result show up
    in_calm  = 1'b0;
    out_calm = 1'b0;
    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);

    $display("covered %0d requests: %0d loads, %0d queries, %0d clears, %0d unused codes",
             n_sent + n_unused, n_loads, n_queries, n_clears, n_unused);
    $display("%0d results checked, %0d sets closed as subsets, %0d loads dropped on a full table",
             checked, subset_sets, dropped_loads);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
